/* rtl/accept_encoding_negotiator_core_macros.svh */
// Assertion macros used by the negotiator parser.
`ifndef ACCEPT_ENCODING_NEGOTIATOR_CORE_MACROS_SVH
`define ACCEPT_ENCODING_NEGOTIATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AEN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AEN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aen_pkg.sv */
// Types and constants of the Accept-Encoding negotiator.
package aen_pkg;

  localparam logic [9:0] QualityMax = 10'd1000;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_TOKEN = 3'd1,
    PH_SEMI  = 3'd2,
    PH_Q     = 3'd3,
    PH_EQ    = 3'd4,
    PH_INT   = 3'd5,
    PH_FRAC  = 3'd6
  } aen_phase_e;

  typedef enum logic [1:0] {
    ENC_IDENTITY = 2'd0,
    ENC_GZIP     = 2'd1,
    ENC_NONE     = 2'd2
  } aen_enc_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       has_byte;
    logic       last;
  } aen_item_t;

  typedef struct packed {
    logic     valid;
    aen_enc_e encoding;
  } aen_res_t;

  typedef struct packed {
    aen_phase_e phase;
    logic [3:0] pos;
    logic [3:0] alive;
    logic       pend;
    logic       dropped;
    logic [9:0] qacc;
    logic [1:0] qdig;
    logic       qone;
  } aen_elem_t;

  typedef struct packed {
    logic [9:0] gzip_q;
    logic       gzip_seen;
    logic [9:0] ident_q;
    logic       ident_seen;
    logic [9:0] wild_q;
    logic       wild_seen;
    logic       saw_any;
  } aen_tab_t;

  localparam aen_elem_t ElemClear = '{
    phase: PH_LEAD, pos: 4'd0, alive: 4'hF, pend: 1'b0, dropped: 1'b0,
    qacc: QualityMax, qdig: 2'd0, qone: 1'b0
  };

  localparam aen_tab_t TabClear = '{
    gzip_q: 10'd0, gzip_seen: 1'b0, ident_q: 10'd0, ident_seen: 1'b0,
    wild_q: 10'd0, wild_seen: 1'b0, saw_any: 1'b0
  };

  // Candidate tokens
  localparam int CandGzip  = 0;
  localparam int CandXGzip = 1;
  localparam int CandIdent = 2;
  localparam int CandWild  = 3;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharLowQ  = 8'h71;
  localparam logic [7:0] CharUpQ   = 8'h51;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;

endpackage

/* rtl/aen_ifs.sv */
// Valid/ready channel interfaces for header bytes and decisions.
interface aen_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, header_byte, has_byte, last, input ready);
  modport sink   (input valid, header_byte, has_byte, last, output ready);
endinterface

interface aen_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] encoding;

  modport source (output valid, encoding, input ready);
  modport sink   (input valid, encoding, output ready);
endinterface

/* rtl/aen_in_stage.sv */
// Input register for header words.
module aen_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  aen_in_if.sink              in_i,
  input  logic                take_i,
  output logic                item_valid_o,
  output aen_pkg::aen_item_t  item_o
);

  logic               valid_q, valid_d;
  aen_pkg::aen_item_t item_q, item_d;
  logic               load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = '{header_byte: in_i.header_byte, has_byte: in_i.has_byte,
                  last: in_i.last};
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/aen_parser.sv */
// Element parser, per-token quality table and final decision.
`include "accept_encoding_negotiator_core_macros.svh"

module aen_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  aen_pkg::aen_item_t  item_i,
  input  logic                res_ready_i,
  output logic                take_o,
  output aen_pkg::aen_res_t   res_o
);

  aen_pkg::aen_elem_t elem_q, elem_d, elem_w, fin_src;
  aen_pkg::aen_tab_t  tab_q, tab_d, tab_w;
  logic               is_comma;

  function automatic logic [3:0] cand_len(logic [1:0] k);
    logic [3:0] l;
    l = 4'd1;
    unique case (k)
      2'(aen_pkg::CandGzip):  l = 4'd4;
      2'(aen_pkg::CandXGzip): l = 4'd6;
      2'(aen_pkg::CandIdent): l = 4'd8;
      default:                l = 4'd1;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] cand_char(logic [1:0] k, logic [2:0] p);
    logic [63:0] t;
    t = '0;
    unique case (k)
      2'(aen_pkg::CandGzip):  t = {"gzip", 32'h0};
      2'(aen_pkg::CandXGzip): t = {"x-gzip", 16'h0};
      2'(aen_pkg::CandIdent): t = "identity";
      default:                t = {"*", 56'h0};
    endcase
    t = t << {p, 3'b000};
    return t[63:56];
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == aen_pkg::CharSpace) || (c >= aen_pkg::CharTab && c <= aen_pkg::CharCr);
  endfunction

  function automatic aen_pkg::aen_elem_t take_char(aen_pkg::aen_elem_t e, logic [7:0] c);
    aen_pkg::aen_elem_t n;
    logic [7:0]         f;
    n = e;
    f = (c >= aen_pkg::CharUpA && c <= aen_pkg::CharUpZ) ? (c | 8'h20) : c;
    for (int k = 0; k < 4; k++) begin
      if (e.alive[k] && (e.pos >= cand_len(2'(k)) || cand_char(2'(k), e.pos[2:0]) != f)) begin
        n.alive[k] = 1'b0;
      end
    end
    if (e.pos != 4'hF) n.pos = e.pos + 4'd1;
    return n;
  endfunction

  function automatic aen_pkg::aen_elem_t feed(aen_pkg::aen_elem_t e, logic [7:0] c);
    aen_pkg::aen_elem_t n;
    logic               ws;
    logic [9:0]         place;
    n  = e;
    ws = is_ws(c);
    place = 10'd1;
    if (!e.dropped) begin
      unique case (e.phase)
        aen_pkg::PH_LEAD: begin
          if (!ws) begin
            if (c == aen_pkg::CharSemi) begin
              n.phase = aen_pkg::PH_SEMI;
            end else begin
              n = take_char(e, c);
              n.phase = aen_pkg::PH_TOKEN;
            end
          end
        end
        aen_pkg::PH_TOKEN: begin
          if (ws) begin
            n.pend = 1'b1;
          end else if (c == aen_pkg::CharSemi) begin
            n.phase = aen_pkg::PH_SEMI;
            n.pend  = 1'b0;
          end else begin
            // inner whitespace kills every candidate
            if (e.pend) begin
              n.alive = 4'h0;
              n.pend  = 1'b0;
            end
            n = take_char(n, c);
          end
        end
        aen_pkg::PH_SEMI: begin
          if (!ws) begin
            if (c == aen_pkg::CharLowQ || c == aen_pkg::CharUpQ) n.phase = aen_pkg::PH_Q;
            else n.dropped = 1'b1;
          end
        end
        aen_pkg::PH_Q: begin
          if (!ws) begin
            if (c == aen_pkg::CharEq) n.phase = aen_pkg::PH_EQ;
            else n.dropped = 1'b1;
          end
        end
        aen_pkg::PH_EQ: begin
          if (!ws) begin
            if (c == aen_pkg::CharZero || c == aen_pkg::CharOne) begin
              n.qone  = (c == aen_pkg::CharOne);
              n.qacc  = (c == aen_pkg::CharOne) ? aen_pkg::QualityMax : 10'd0;
              n.phase = aen_pkg::PH_INT;
            end else begin
              n.dropped = 1'b1;
            end
          end
        end
        aen_pkg::PH_INT: begin
          if (ws) n.pend = 1'b1;
          else if (!e.pend && c == aen_pkg::CharDot) n.phase = aen_pkg::PH_FRAC;
          else n.dropped = 1'b1;
        end
        aen_pkg::PH_FRAC: begin
          if (ws) begin
            n.pend = 1'b1;
          end else if (e.pend || c < aen_pkg::CharZero || c > aen_pkg::CharNine ||
                       e.qdig == 2'd3 || (e.qone && c != aen_pkg::CharZero)) begin
            n.dropped = 1'b1;
          end else begin
            case (e.qdig)
              2'd0:    place = 10'd100;
              2'd1:    place = 10'd10;
              default: place = 10'd1;
            endcase
            if (!e.qone) n.qacc = e.qacc + 10'(c[3:0]) * place;
            n.qdig = e.qdig + 2'd1;
          end
        end
        default: n.dropped = 1'b1;
      endcase
    end
    return n;
  endfunction

  function automatic logic cand_hit(aen_pkg::aen_elem_t e, int k);
    return e.alive[k] && (e.pos == cand_len(2'(k)));
  endfunction

  function automatic aen_pkg::aen_tab_t finish(aen_pkg::aen_elem_t e, aen_pkg::aen_tab_t t);
    aen_pkg::aen_tab_t n;
    logic              ok;
    logic [9:0]        q;
    n  = t;
    ok = 1'b0;
    q  = aen_pkg::QualityMax;
    if (!e.dropped) begin
      if (e.phase == aen_pkg::PH_TOKEN) begin
        ok = 1'b1;
      end else if (e.phase == aen_pkg::PH_INT || e.phase == aen_pkg::PH_FRAC) begin
        ok = 1'b1;
        q  = e.qacc;
      end
    end
    if (ok) begin
      // first occurrence of each token wins
      if ((cand_hit(e, aen_pkg::CandGzip) || cand_hit(e, aen_pkg::CandXGzip)) &&
          !t.gzip_seen) begin
        n.gzip_seen = 1'b1;
        n.gzip_q    = q;
      end else if (cand_hit(e, aen_pkg::CandIdent) && !t.ident_seen) begin
        n.ident_seen = 1'b1;
        n.ident_q    = q;
      end else if (cand_hit(e, aen_pkg::CandWild) && !t.wild_seen) begin
        n.wild_seen = 1'b1;
        n.wild_q    = q;
      end
    end
    return n;
  endfunction

  function automatic aen_pkg::aen_enc_e decide(aen_pkg::aen_tab_t t);
    logic [9:0]        gq, iq;
    aen_pkg::aen_enc_e r;
    gq = t.gzip_seen ? t.gzip_q : (t.wild_seen ? t.wild_q : 10'd0);
    if (t.ident_seen) iq = t.ident_q;
    else iq = (t.wild_seen && t.wild_q == 10'd0) ? 10'd0 : aen_pkg::QualityMax;
    if (!t.saw_any) r = aen_pkg::ENC_IDENTITY;
    else if (gq != 10'd0 && gq >= iq) r = aen_pkg::ENC_GZIP;
    else if (iq != 10'd0) r = aen_pkg::ENC_IDENTITY;
    else r = aen_pkg::ENC_NONE;
    return r;
  endfunction

  // A last word needs room in the result register.
  assign take_o   = item_valid_i && (!item_i.last || res_ready_i);
  assign is_comma = item_i.has_byte && (item_i.header_byte == aen_pkg::CharComma);

  always_comb begin
    tab_w   = tab_q;
    elem_w  = elem_q;
    fin_src = elem_q;
    if (item_i.has_byte) begin
      tab_w.saw_any = 1'b1;
      if (!is_comma) begin
        elem_w  = feed(elem_q, item_i.header_byte);
        fin_src = elem_w;
      end else begin
        elem_w  = aen_pkg::ElemClear;
      end
    end
    if (is_comma || item_i.last) tab_w = finish(fin_src, tab_w);
  end

  always_comb begin
    elem_d         = elem_q;
    tab_d          = tab_q;
    res_o.valid    = 1'b0;
    res_o.encoding = aen_pkg::ENC_IDENTITY;
    if (take_o) begin
      if (item_i.last) begin
        res_o.valid    = 1'b1;
        res_o.encoding = decide(tab_w);
        elem_d         = aen_pkg::ElemClear;
        tab_d          = aen_pkg::TabClear;
      end else begin
        elem_d = elem_w;
        tab_d  = tab_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= aen_pkg::ElemClear;
      tab_q  <= aen_pkg::TabClear;
    end else begin
      elem_q <= elem_d;
      tab_q  <= tab_d;
    end
  end

  `AEN_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, take_o && item_i.last, (elem_q == aen_pkg::ElemClear) && (tab_q == aen_pkg::TabClear), "state not cleared after last word")
  `AEN_ASSERT_NEXT(a_saw_byte, clk_i, rst_ni, take_o && item_i.has_byte && !item_i.last, tab_q.saw_any, "byte not recorded")
  `AEN_ASSERT_NOW(a_seen_needs_byte, clk_i, rst_ni, tab_q.gzip_seen || tab_q.ident_seen || tab_q.wild_seen, tab_q.saw_any, "token recorded without any byte")
  `AEN_ASSERT_NOW(a_qacc_range, clk_i, rst_ni, 1'b1, elem_q.qacc <= aen_pkg::QualityMax, "quality above 1000")

endmodule

/* rtl/aen_out_stage.sv */
// Result register driving the decision channel.
module aen_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aen_pkg::aen_res_t  res_i,
  output logic               ready_o,
  aen_out_if.source          out_o
);

  logic              valid_q, valid_d;
  aen_pkg::aen_enc_e enc_q, enc_d;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    enc_d   = enc_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
      enc_d   = res_i.encoding;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    enc_q <= enc_d;
  end

  assign out_o.valid    = valid_q;
  assign out_o.encoding = enc_q;

endmodule

/* rtl/accept_encoding_negotiator_core.sv */
// Flow: a header word accepted into the input register is parsed in the following cycle; the decision
//   of a last word is loaded into the result register at the edge at which the parser takes that word.
// Throughput: one word per cycle; only a last word waits, and only while the result register
//   holds a decision that the receiver does not take in that cycle.
// Reset (asynchronous, active low) empties both registers and returns the parser and the
//   token table to the start of a header; no clearing pass is needed.
module accept_encoding_negotiator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  aen_in_if.sink     in_i,
  aen_out_if.source  out_o
);

  // input register -> parser (state update, decision) -> result register
  logic               item_valid;
  aen_pkg::aen_item_t item;
  logic               take;
  logic               res_ready;
  aen_pkg::aen_res_t  res;

  // Holds one header word; freed in the cycle the parser consumes it.
  aen_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Trims and splits elements, matches tokens, scales q values and, on the
  // last word, closes the open element and forms the decision.
  aen_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .res_ready_i  (res_ready),
    .take_o       (take),
    .res_o        (res)
  );

  // One-entry result register; reloadable in the cycle it is drained.
  aen_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .ready_o (res_ready),
    .out_o   (out_o)
  );

endmodule

/* tb/sv/accept_encoding_negotiator_core_test.sv */
// Self-checking testbench for the Accept-Encoding negotiator core.
module accept_encoding_negotiator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aen_pkg::*;

  localparam logic [7:0] LetterA    = 8'h61;
  localparam int         WordTarget = 1650;

  // Receiver back-pressure patterns, re-chosen at random at regular intervals.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_THIRDS,
    RX_SPARSE
  } rx_pattern_e;

  // Shapes of the q parameter the generator can emit; all but the first are malformed.
  typedef enum int {
    QV_GOOD,
    QV_BAD_LETTER,
    QV_EMPTY,
    QV_NO_EQ,
    QV_BAD_INT,
    QV_INNER_SPACE,
    QV_LONG_FRAC,
    QV_ONE_FRAC,
    QV_EXTRA_SEMI
  } qv_shape_e;

  // Tracks the parse of the header in flight and the decisions still owed by the core.
  class negotiation_tracker;
    aen_elem_t el;
    aen_tab_t  tab;
    aen_enc_e  decisions_due[$];
    int        errors;

    function new();
      el     = ElemClear;
      tab    = TabClear;
      errors = 0;
    endfunction

    function string cand_name(int k);
      case (k)
        CandGzip:  return "gzip";
        CandXGzip: return "x-gzip";
        CandIdent: return "identity";
        default:   return "*";
      endcase
    endfunction

    function bit cand_hit(int k);
      string txt;
      txt = cand_name(k);
      return el.alive[k] && el.pos == txt.len();
    endfunction

    // Candidate match on the lowered byte; '*' is unaffected by lowering.
    function void take_char(logic [7:0] c);
      logic [7:0] f;
      string      txt;
      f = (c >= CharUpA && c <= CharUpZ) ? c + 8'd32 : c;
      for (int k = 0; k < 4; k++) begin
        txt = cand_name(k);
        if (el.alive[k] && (el.pos >= txt.len() || txt[el.pos] != f)) el.alive[k] = 1'b0;
      end
      if (el.pos != 4'd15) el.pos = el.pos + 4'd1;
    endfunction

    // First well-formed element per token wins.
    function void close_element();
      bit         ok;
      logic [9:0] q;
      ok = 1'b0;
      q  = QualityMax;
      if (!el.dropped && el.phase == PH_TOKEN) begin
        ok = 1'b1;
      end else if (!el.dropped && (el.phase == PH_INT || el.phase == PH_FRAC)) begin
        ok = 1'b1;
        q  = el.qacc;
      end
      if (ok) begin
        if ((cand_hit(CandGzip) || cand_hit(CandXGzip)) && !tab.gzip_seen) begin
          tab.gzip_seen = 1'b1;
          tab.gzip_q    = q;
        end else if (cand_hit(CandIdent) && !tab.ident_seen) begin
          tab.ident_seen = 1'b1;
          tab.ident_q    = q;
        end else if (cand_hit(CandWild) && !tab.wild_seen) begin
          tab.wild_seen = 1'b1;
          tab.wild_q    = q;
        end
      end
      el = ElemClear;
    endfunction

    function void note_word(aen_item_t w);
      logic [7:0] c;
      logic [7:0] digit;
      bit         ws;
      logic [9:0] gq;
      logic [9:0] iq;
      aen_enc_e   enc;
      c     = w.header_byte;
      digit = c - CharZero;
      ws    = c == CharSpace || (c >= CharTab && c <= CharCr);
      if (w.has_byte) begin
        tab.saw_any = 1'b1;
        if (c == CharComma) begin
          close_element();
        end else if (!el.dropped) begin
          case (el.phase)
            PH_LEAD: begin
              if (c == CharSemi) begin
                el.phase = PH_SEMI;
              end else if (!ws) begin
                el.phase = PH_TOKEN;
                take_char(c);
              end
            end
            PH_TOKEN: begin
              if (ws) begin
                el.pend = 1'b1;
              end else if (c == CharSemi) begin
                el.phase = PH_SEMI;
                el.pend  = 1'b0;
              end else begin
                // text after inner whitespace kills every candidate
                if (el.pend) begin
                  el.alive = 4'd0;
                  el.pend  = 1'b0;
                end
                take_char(c);
              end
            end
            PH_SEMI: begin
              if (!ws) begin
                if (c == CharLowQ || c == CharUpQ) el.phase = PH_Q;
                else el.dropped = 1'b1;
              end
            end
            PH_Q: begin
              if (!ws) begin
                if (c == CharEq) el.phase = PH_EQ;
                else el.dropped = 1'b1;
              end
            end
            PH_EQ: begin
              if (!ws) begin
                if (c == CharZero || c == CharOne) begin
                  el.qone  = (c == CharOne);
                  el.qacc  = el.qone ? QualityMax : 10'd0;
                  el.phase = PH_INT;
                end else begin
                  el.dropped = 1'b1;
                end
              end
            end
            PH_INT: begin
              if (ws) el.pend = 1'b1;
              else if (!el.pend && c == CharDot) el.phase = PH_FRAC;
              else el.dropped = 1'b1;
            end
            PH_FRAC: begin
              if (ws) begin
                el.pend = 1'b1;
              end else if (el.pend || c < CharZero || c > CharNine || el.qdig == 2'd3 ||
                           (el.qone && c != CharZero)) begin
                el.dropped = 1'b1;
              end else begin
                if (!el.qone) begin
                  el.qacc = el.qacc + ((el.qdig == 2'd0) ? 10'(digit) * 10'd100 :
                                       (el.qdig == 2'd1) ? 10'(digit) * 10'd10 :
                                       10'(digit));
                end
                el.qdig = el.qdig + 2'd1;
              end
            end
            default: el.dropped = 1'b1;
          endcase
        end
      end
      if (w.last) begin
        close_element();
        if (!tab.saw_any) begin
          enc = ENC_IDENTITY;
        end else begin
          gq = tab.gzip_seen ? tab.gzip_q : (tab.wild_seen ? tab.wild_q : 10'd0);
          if (tab.ident_seen) iq = tab.ident_q;
          else iq = (tab.wild_seen && tab.wild_q == 10'd0) ? 10'd0 : QualityMax;
          if (gq != 10'd0 && gq >= iq) enc = ENC_GZIP;
          else if (iq != 10'd0) enc = ENC_IDENTITY;
          else enc = ENC_NONE;
        end
        decisions_due.push_back(enc);
        el  = ElemClear;
        tab = TabClear;
      end
    endfunction

    function void check_decision(logic [1:0] enc);
      aen_enc_e want;
      if (decisions_due.size() == 0) begin
        $error("encoding: expected none, actual %0d", enc);
        errors++;
      end else begin
        want = decisions_due.pop_front();
        if (enc !== want) begin
          $error("encoding: expected %0d, actual %0d", want, enc);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  aen_in_if  in_if ();
  aen_out_if out_if ();

  accept_encoding_negotiator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  negotiation_tracker board;

  // Header text under construction, one entry per byte word.
  logic [7:0] hdr_bytes[$];

  int burst_left   = 0;  // words left in the current sender burst
  bit sender_eager = 0;  // suppresses sender gaps while the receiver holds off
  int hold_request = 0;  // cycles of hold-off asked of the receiver
  int words_sent   = 0;  // words that carry a byte or close a header

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Outputs are sampled at the rising edge, before any NBA of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) board.check_decision(out_if.encoding);
  end

  // Receiver: its own stall pattern, plus a long hold-off counted here on request.
  initial begin : rx_side
    int          hold_left;
    int          tick;
    rx_pattern_e mode;
    hold_left = 0;
    tick      = 0;
    mode      = RX_OPEN;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 50 == 0) mode = rx_pattern_e'($urandom_range(0, 3));
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_THIRDS: out_if.ready <= (tick % 3) != 0;
          default:   out_if.ready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // Offers one word and returns once it has been taken. Bursts of random length with
  // random gaps between them; a gap of zero runs one burst straight into the next.
  task automatic push_word(input logic [7:0] b, input logic has, input logic lst);
    aen_item_t w;
    int        gap;
    w = '{header_byte: b, has_byte: has, last: lst};
    if (burst_left == 0 && !sender_eager) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid       <= 1'b1;
    in_if.header_byte <= b;
    in_if.has_byte    <= has;
    in_if.last        <= lst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_word(w);
    if (has || lst) words_sent++;
  endtask

  // Sends the buffered header. The close either rides on the final byte or comes as a
  // separate word with no byte; an empty header is always closed that way.
  task automatic send_header(input bit close_apart);
    for (int i = 0; i < hdr_bytes.size(); i++) begin
      // now and then a word with no byte and no close, which the core must ignore
      if ($urandom_range(0, 23) == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_word(hdr_bytes[i], 1'b1, !close_apart && i == hdr_bytes.size() - 1);
    end
    if (close_apart || hdr_bytes.size() == 0) begin
      push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    hdr_bytes.delete();
  endtask

  // Any of the six whitespace bytes.
  function automatic void put_ws(int max_n);
    int r;
    repeat ($urandom_range(0, max_n)) begin
      r = $urandom_range(0, 5);
      hdr_bytes.push_back(r == 0 ? CharSpace : CharTab + 8'(r - 1));
    end
  endfunction

  function automatic void put_text(string s, bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= LetterA && c < LetterA + 8'd26 && $urandom_range(0, 1) == 1) begin
        c = c - 8'd32;
      end
      hdr_bytes.push_back(c);
    end
  endfunction

  // Mostly well-formed element lists with random content; some raw noise, some broken
  // tokens and broken q values.
  function automatic void build_header();
    int          n_el;
    int          shape_pick;
    int          tok;
    int          pick;
    int          nd;
    qv_shape_e   qv;
    logic [7:0]  d;
    string       s;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) hdr_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_el = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    for (int e = 0; e < n_el; e++) begin
      if (e > 0) hdr_bytes.push_back(CharComma);
      put_ws(2);
      shape_pick = $urandom_range(0, 15);
      if (shape_pick == 15) continue;  // empty element, whitespace at most
      tok = (shape_pick == 14) ? -1 : $urandom_range(0, 9);
      case (tok)
        0, 1: put_text("gzip", 1'b1);
        2:    put_text("x-gzip", 1'b1);
        3, 4: put_text("identity", 1'b1);
        5, 6: put_text("*", 1'b0);
        7: begin
          // junk, now and then long enough to saturate the position count
          repeat ($urandom_range(1, 18)) hdr_bytes.push_back(LetterA + 8'($urandom_range(0, 25)));
        end
        8: begin
          // near miss: candidate one short or one long
          s = board.cand_name($urandom_range(0, 3));
          if ($urandom_range(0, 1) == 1) s = s.substr(0, s.len() - 2);
          else s = {s, "s"};
          put_text(s, 1'b1);
        end
        9: begin
          // whitespace inside the token
          put_text("gz", 1'b1);
          hdr_bytes.push_back(CharSpace);
          put_text("ip", 1'b1);
        end
        default: ;
      endcase
      put_ws(1);
      pick = $urandom_range(0, 9);
      if (shape_pick == 14 || pick >= 4) begin
        qv = (pick == 9) ? qv_shape_e'($urandom_range(1, 8)) : QV_GOOD;
        hdr_bytes.push_back(CharSemi);
        put_ws(1);
        if (qv != QV_EMPTY) begin
          hdr_bytes.push_back(qv == QV_BAD_LETTER ? LetterA + 8'($urandom_range(0, 15)) :
                              ($urandom_range(0, 1) == 1 ? CharLowQ : CharUpQ));
          put_ws(1);
          if (qv != QV_NO_EQ) hdr_bytes.push_back(CharEq);
          put_ws(1);
          if (qv == QV_BAD_INT) d = CharZero + 8'($urandom_range(2, 9));
          else if (qv == QV_ONE_FRAC) d = CharOne;
          else d = ($urandom_range(0, 1) == 1) ? CharOne : CharZero;
          hdr_bytes.push_back(d);
          if (qv == QV_INNER_SPACE) hdr_bytes.push_back(CharSpace);
          if (qv == QV_INNER_SPACE || qv == QV_LONG_FRAC || qv == QV_ONE_FRAC ||
              $urandom_range(0, 2) != 0) begin
            hdr_bytes.push_back(CharDot);
            if (qv == QV_LONG_FRAC) nd = 4;
            else if (qv == QV_ONE_FRAC) nd = $urandom_range(1, 3);
            else nd = $urandom_range(0, 3);
            for (int i = 0; i < nd; i++) begin
              if (d != CharOne) hdr_bytes.push_back(CharZero + 8'($urandom_range(0, 9)));
              else if (qv == QV_ONE_FRAC && i == nd - 1)
                hdr_bytes.push_back(CharZero + 8'($urandom_range(1, 9)));
              else hdr_bytes.push_back(CharZero);
            end
          end
          if (qv == QV_EXTRA_SEMI) hdr_bytes.push_back(CharSemi);
        end
        put_ws(1);
      end
    end
  endfunction

  // Run after a generous fixed time.
  initial begin : watchdog
    #2_000_000;
    $display("accept_encoding_negotiator_core_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int hdr_count;
    board  = new();
    rst_ni = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.header_byte <= 8'h00;
    in_if.has_byte    <= 1'b0;
    in_if.last        <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty header, wildcard at zero, upper-case gzip, NUL and 0xFF bytes
    // closed by a byteless word, gzip refused by q=0.
    send_header(1'b1);
    put_text("*;q=0", 1'b0);
    send_header(1'b0);
    put_text("GZIP", 1'b0);
    send_header(1'b0);
    push_word(8'h5A, 1'b0, 1'b0);
    hdr_bytes = '{8'h00, 8'hFF};
    send_header(1'b1);
    put_text("gzip;q=0", 1'b0);
    send_header(1'b0);

    hdr_count = 0;
    while (words_sent < WordTarget) begin
      hdr_count++;
      if (hdr_count == 15 || hdr_count == 45) begin
        // Long receiver hold-off while short headers keep coming: the result register
        // fills and the core must stall its input.
        hold_request = 400;
        sender_eager = 1'b1;
        repeat (12) begin
          if ($urandom_range(0, 1) == 1) put_text("gzip", 1'b1);
          send_header($urandom_range(0, 2) == 0);
        end
        sender_eager = 1'b0;
      end
      if (hdr_count == 30) begin
        // sender pauses until every owed decision is out
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (board.decisions_due.size() != 0);
      end
      build_header();
      send_header($urandom_range(0, 5) == 0);
    end
    in_if.valid <= 1'b0;

    // Drain, then watch for anything spurious before finishing.
    while (board.decisions_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("accept_encoding_negotiator_core_test: done, clean");
    end else begin
      $display("accept_encoding_negotiator_core_test: done, errors");
    end
    $finish;
  end

endmodule
